// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on clock and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lsmp_pkg.sv =====
package lsmp_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAT_XX,
      REG_MAT_XY,
      REG_MAT_YX,
      REG_MAT_YY,
      REG_OFFSET_X,
      REG_OFFSET_Y,
      REG_ANGLE_START,
      REG_ANGLE_STEP
   } reg_index_type;

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } quad_type;

   localparam logic [15:0] RANGE_MIN_MM = 16'd100;
   localparam logic [15:0] RANGE_MAX_MM = 16'd30000;

   // quarter turn in fraction units
   localparam logic [14:0] QUARTER_TURN = 15'd16384;

   // sine polynomial coefficients, Q30; seed is the degree 9 term
   localparam int HORNER_DEPTH = 4;
   localparam logic [30:0] HORNER_SEED = 31'd172272;
   localparam logic [30:0] HORNER_COEF [0:HORNER_DEPTH-1] = '{
      31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
   };

   typedef struct packed {
      logic signed [15:0] mat_xx;
      logic signed [15:0] mat_xy;
      logic signed [15:0] mat_yx;
      logic signed [15:0] mat_yy;
      logic signed [23:0] offset_x;
      logic signed [23:0] offset_y;
      logic        [15:0] angle_start;
      logic signed [15:0] angle_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mat_xx:      -16'sd16384,
      mat_xy:      16'sd0,
      mat_yx:      16'sd0,
      mat_yy:      16'sd16384,
      offset_x:    24'sd0,
      offset_y:    24'sd0,
      angle_start: 16'd0,
      angle_step:  16'sd0
   };

   typedef struct packed {
      logic [15:0] range_mm;
      logic        range_finite;
      logic        scan_first;
      logic        scan_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0] point_x;
      logic signed [23:0] point_y;
      logic               point_kept;
      logic               scan_end;
   } rsp_payload_type;

   // one trig evaluation travelling down the Horner chain
   typedef struct packed {
      logic        valid;
      logic        is_cos;
      logic [14:0] f;
      logic [30:0] u;
      logic [30:0] acc;
   } lane_type;

   typedef struct packed {
      logic [15:0] range_mm;
      quad_type    quad;
      logic        kept;
      logic        last;
   } ctx_type;

endpackage

// ===== hw/rtl/lsmp_chan_if.sv =====
interface lsmp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lidar_scan_to_map_points_unit.sv =====
// channel   dir  payload                                          handshake
// req_chan  in   range_mm, range_finite, scan_first, scan_last    valid/ready
// rsp_chan  out  point_x, point_y, point_kept, scan_end           valid/ready
// csr_*     in   csr_index, csr_wdata                             csr_wr_en, no wait
//
// One item at a time: the ST_FEED_SIN and ST_FEED_COS states feed sine
// then cosine into the four-cell Horner chain, one shared multiply
// finishes each, then scale, matrix, round and saturate stages, then the
// output register. A new item is taken while a result waits in the output
// register; a result finishing behind a stalled one waits in its stage.
// Reset (synchronous) loads the register defaults and clears the beam angle.
`include "assert_macros.svh"

module lidar_scan_to_map_points_unit #(
   parameter logic [15:0] RANGE_MIN_MM = lsmp_pkg::RANGE_MIN_MM,
   parameter logic [15:0] RANGE_MAX_MM = lsmp_pkg::RANGE_MAX_MM
) (
   input  logic                               clock,
   input  logic                               reset,
   lsmp_chan_if.sink                          req_chan,
   lsmp_chan_if.source                        rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [lsmp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lsmp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED_SIN,
      ST_FEED_COS,
      ST_RUN,
      ST_PEND
   } state_type;

   lsmp_pkg::cfg_type         cfg;
   lsmp_pkg::lane_type        chain_lane [0:lsmp_pkg::HORNER_DEPTH];
   logic [lsmp_pkg::HORNER_DEPTH:0] chain_vmask;
   logic                      xf_done;
   lsmp_pkg::rsp_payload_type xf_result;

   state_type                 state_ff, state_in;
   logic [15:0]               beam_ff, beam_in;
   logic [15:0]               a_ff, a_in;
   lsmp_pkg::ctx_type         ctx_ff, ctx_in;
   lsmp_pkg::lane_type        inj_ff, inj_in;
   logic                      out_valid_ff, out_valid_in;
   lsmp_pkg::rsp_payload_type out_ff, out_in;

   logic        accept;
   logic        out_free;
   logic [15:0] angle_sel;
   logic [14:0] feed_f;
   logic [29:0] feed_sq;
   logic        sin_fed;
   logic        cos_fed;

   lsmp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign chain_lane[0]  = inj_ff;
   assign chain_vmask[0] = inj_ff.valid;

   for (genvar i = 0; i < lsmp_pkg::HORNER_DEPTH; i++) begin : g_cell
      lsmp_horner_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .coef    (lsmp_pkg::HORNER_COEF[i]),
         .up_lane (chain_lane[i]),
         .dn_lane (chain_lane[i+1])
      );
      assign chain_vmask[i+1] = chain_lane[i+1].valid;
   end

   lsmp_xform u_xform (
      .clock  (clock),
      .reset  (reset),
      .lane   (chain_lane[lsmp_pkg::HORNER_DEPTH]),
      .ctx    (ctx_ff),
      .cfg    (cfg),
      .done   (xf_done),
      .result (xf_result)
   );

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign accept           = req_chan.valid && req_chan.ready;
   assign out_free         = !out_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   assign angle_sel = req_chan.payload.scan_first ? cfg.angle_start : beam_ff;

   // cosine runs the same polynomial on the complementary fraction
   assign feed_f  = (state_ff == ST_FEED_COS) ? lsmp_pkg::QUARTER_TURN - {1'b0, a_ff[13:0]}
                                              : {1'b0, a_ff[13:0]};
   assign feed_sq = feed_f * feed_f;

   assign sin_fed = inj_ff.valid && !inj_ff.is_cos;
   assign cos_fed = inj_ff.valid && inj_ff.is_cos;

   always_comb begin
      state_in     = state_ff;
      beam_in      = beam_ff;
      a_in         = a_ff;
      ctx_in       = ctx_ff;
      inj_in       = inj_ff;
      inj_in.valid = 1'b0;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in            = angle_sel;
               beam_in         = angle_sel + cfg.angle_step;
               ctx_in.range_mm = req_chan.payload.range_mm;
               ctx_in.quad     = lsmp_pkg::quad_type'(angle_sel[15:14]);
               ctx_in.kept     = req_chan.payload.range_finite
                                 && (req_chan.payload.range_mm > RANGE_MIN_MM)
                                 && (req_chan.payload.range_mm < RANGE_MAX_MM);
               ctx_in.last     = req_chan.payload.scan_last;
               state_in        = ST_FEED_SIN;
            end
         end
         ST_FEED_SIN, ST_FEED_COS: begin
            inj_in.valid  = 1'b1;
            inj_in.is_cos = (state_ff == ST_FEED_COS);
            inj_in.f      = feed_f;
            inj_in.u      = {feed_sq[28:0], 2'b00};
            inj_in.acc    = lsmp_pkg::HORNER_SEED;
            state_in      = (state_ff == ST_FEED_COS) ? ST_RUN : ST_FEED_COS;
         end
         ST_RUN: begin
            if (xf_done) begin
               if (out_free) begin
                  out_in       = xf_result;
                  out_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in     = ST_PEND;
               end
            end
         end
         ST_PEND: begin
            if (out_free) begin
               out_in       = xf_result;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         beam_ff      <= '0;
         inj_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beam_ff      <= beam_in;
         inj_ff       <= inj_in;
         out_valid_ff <= out_valid_in;
      end
      a_ff   <= a_in;
      ctx_ff <= ctx_in;
      out_ff <= out_in;
   end

   `ASSERT_IMPLIES(a_done_in_run, xf_done, state_ff == ST_RUN, "result done outside run state")
   `ASSERT_IMPLIES(a_pend_out_full, state_ff == ST_PEND, out_valid_ff, "pending with free output")
   `ASSERT_NEXT(a_cos_after_sin, sin_fed, cos_fed, "cosine lane missing after sine")
   `ASSERT_IMPLIES(a_chain_empty_on_accept, accept, chain_vmask == '0, "accept with busy chain")

endmodule

// ===== hw/rtl/lsmp_csr.sv =====
module lsmp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [lsmp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lsmp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output lsmp_pkg::cfg_type                  cfg
);

   lsmp_pkg::cfg_type cfg_ff;
   lsmp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (lsmp_pkg::reg_index_type'(csr_index))
            lsmp_pkg::REG_MAT_XX:      cfg_in.mat_xx      = csr_wdata[15:0];
            lsmp_pkg::REG_MAT_XY:      cfg_in.mat_xy      = csr_wdata[15:0];
            lsmp_pkg::REG_MAT_YX:      cfg_in.mat_yx      = csr_wdata[15:0];
            lsmp_pkg::REG_MAT_YY:      cfg_in.mat_yy      = csr_wdata[15:0];
            lsmp_pkg::REG_OFFSET_X:    cfg_in.offset_x    = csr_wdata[23:0];
            lsmp_pkg::REG_OFFSET_Y:    cfg_in.offset_y    = csr_wdata[23:0];
            lsmp_pkg::REG_ANGLE_START: cfg_in.angle_start = csr_wdata[15:0];
            lsmp_pkg::REG_ANGLE_STEP:  cfg_in.angle_step  = csr_wdata[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lsmp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/lsmp_horner_cell.sv =====
module lsmp_horner_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic [30:0]        coef,
   input  lsmp_pkg::lane_type up_lane,
   output lsmp_pkg::lane_type dn_lane
);

   logic [61:0]        prod;
   lsmp_pkg::lane_type lane_ff;
   lsmp_pkg::lane_type lane_in;

   // acc' = coef - (u * acc) >> 30; the shifted product never exceeds acc
   assign prod = up_lane.u * up_lane.acc;

   always_comb begin
      lane_in     = up_lane;
      lane_in.acc = coef - prod[60:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign dn_lane = lane_ff;

endmodule

// ===== hw/rtl/lsmp_xform.sv =====
module lsmp_xform (
   input  logic                      clock,
   input  logic                      reset,
   input  lsmp_pkg::lane_type        lane,
   input  lsmp_pkg::ctx_type         ctx,
   input  lsmp_pkg::cfg_type         cfg,
   output logic                      done,
   output lsmp_pkg::rsp_payload_type result
);

   localparam logic signed [48:0] ROUND_HALF = 49'sd134217728;
   localparam logic [23:0]        SAT_MAX    = 24'h7FFFFF;
   localparam logic [23:0]        SAT_MIN    = 24'h800000;

   // final Horner step for sine or cosine: magnitude = (f * acc) >> 14
   logic [45:0] fprod;
   logic [30:0] mag;
   logic [30:0] sin_ff, sin_in, cos_ff, cos_in;
   logic        trig_v_ff, trig_v_in;

   assign fprod     = lane.f * lane.acc;
   assign mag       = fprod[44:14];
   assign sin_in    = (lane.valid && !lane.is_cos) ? mag : sin_ff;
   assign cos_in    = (lane.valid && lane.is_cos) ? mag : cos_ff;
   assign trig_v_in = lane.valid && lane.is_cos;

   // quadrant fold and range scaling
   logic [30:0]        cm, sm;
   logic               cn, sn;
   logic [46:0]        xs, ys;
   logic signed [31:0] xl_ff, xl_in, yl_ff, yl_in;
   logic               scale_v_ff;

   always_comb begin
      case (ctx.quad)
         lsmp_pkg::QUAD_0: begin
            cm = cos_ff; cn = 1'b0; sm = sin_ff; sn = 1'b0;
         end
         lsmp_pkg::QUAD_1: begin
            cm = sin_ff; cn = 1'b1; sm = cos_ff; sn = 1'b0;
         end
         lsmp_pkg::QUAD_2: begin
            cm = cos_ff; cn = 1'b1; sm = sin_ff; sn = 1'b1;
         end
         lsmp_pkg::QUAD_3: begin
            cm = sin_ff; cn = 1'b0; sm = cos_ff; sn = 1'b1;
         end
         default: begin
            cm = cos_ff; cn = 1'b0; sm = sin_ff; sn = 1'b0;
         end
      endcase
   end

   assign xs    = ctx.range_mm * cm + 47'd32768;
   assign ys    = ctx.range_mm * sm + 47'd32768;
   assign xl_in = cn ? -$signed({1'b0, xs[46:16]}) : $signed({1'b0, xs[46:16]});
   assign yl_in = sn ? -$signed({1'b0, ys[46:16]}) : $signed({1'b0, ys[46:16]});

   // matrix products
   logic signed [15:0] m_xx, m_xy, m_yx, m_yy;
   logic signed [47:0] pxx_ff, pxx_in, pxy_ff, pxy_in, pyx_ff, pyx_in, pyy_ff, pyy_in;
   logic               prod_v_ff;

   assign m_xx   = cfg.mat_xx;
   assign m_xy   = cfg.mat_xy;
   assign m_yx   = cfg.mat_yx;
   assign m_yy   = cfg.mat_yy;
   assign pxx_in = m_xx * xl_ff;
   assign pxy_in = m_xy * yl_ff;
   assign pyx_in = m_yx * xl_ff;
   assign pyy_in = m_yy * yl_ff;

   // round half up to mm: floor((v + 2^27) / 2^28)
   logic signed [48:0] mx, my;
   logic signed [20:0] rx_ff, rx_in, ry_ff, ry_in;
   logic               sum_v_ff;

   assign mx    = pxx_ff + pxy_ff + ROUND_HALF;
   assign my    = pyx_ff + pyy_ff + ROUND_HALF;
   assign rx_in = mx[48:28];
   assign ry_in = my[48:28];

   // offset and saturate
   logic [24:0]               sx, sy;
   logic [23:0]               satx, saty;
   lsmp_pkg::rsp_payload_type result_ff, result_in;
   logic                      done_ff;

   assign sx   = {{4{rx_ff[20]}}, rx_ff} + {cfg.offset_x[23], cfg.offset_x};
   assign sy   = {{4{ry_ff[20]}}, ry_ff} + {cfg.offset_y[23], cfg.offset_y};
   assign satx = (sx[24] != sx[23]) ? (sx[24] ? SAT_MIN : SAT_MAX) : sx[23:0];
   assign saty = (sy[24] != sy[23]) ? (sy[24] ? SAT_MIN : SAT_MAX) : sy[23:0];

   always_comb begin
      result_in = result_ff;
      if (sum_v_ff) begin
         result_in.point_x    = ctx.kept ? satx : '0;
         result_in.point_y    = ctx.kept ? saty : '0;
         result_in.point_kept = ctx.kept;
         result_in.scan_end   = ctx.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_v_ff  <= 1'b0;
         scale_v_ff <= 1'b0;
         prod_v_ff  <= 1'b0;
         sum_v_ff   <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         trig_v_ff  <= trig_v_in;
         scale_v_ff <= trig_v_ff;
         prod_v_ff  <= scale_v_ff;
         sum_v_ff   <= prod_v_ff;
         done_ff    <= sum_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      sin_ff    <= sin_in;
      cos_ff    <= cos_in;
      result_ff <= result_in;
      if (trig_v_ff) begin
         xl_ff <= xl_in;
         yl_ff <= yl_in;
      end
      if (scale_v_ff) begin
         pxx_ff <= pxx_in;
         pxy_ff <= pxy_in;
         pyx_ff <= pyx_in;
         pyy_ff <= pyy_in;
      end
      if (prod_v_ff) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== sim/lidar_scan_to_map_points_checker.sv =====
module lidar_scan_to_map_points_checker
   import lsmp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_payload_type        req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     points_pending
);

   // Q30 odd Taylor terms of sin(pi/2 * t)
   localparam longint unsigned SIN_C1 = 64'd1686629713;
   localparam longint unsigned SIN_C3 = 64'd693598668;
   localparam longint unsigned SIN_C5 = 64'd85569306;
   localparam longint unsigned SIN_C7 = 64'd5026995;
   localparam longint unsigned SIN_C9 = 64'd172272;
   localparam longint          COORD_MAX = 64'sd8388607;
   localparam longint          COORD_MIN = -64'sd8388608;

   cfg_type         setup;
   logic [15:0]     beam_angle;
   rsp_payload_type point_queue [$];

   function automatic longint unsigned quarter_sine(input logic [14:0] f);
      longint unsigned t;
      longint unsigned u;
      longint unsigned acc;
      t   = 64'(f) << 16;
      u   = (t * t) >> 30;
      acc = SIN_C7 - ((u * SIN_C9) >> 30);
      acc = SIN_C5 - ((u * acc) >> 30);
      acc = SIN_C3 - ((u * acc) >> 30);
      acc = SIN_C1 - ((u * acc) >> 30);
      return (t * acc) >> 30;
   endfunction

   // range times trig magnitude, Q14 mm, sign applied after rounding
   function automatic longint scale_range(input logic [15:0] r, input longint unsigned mag,
                                          input logic neg);
      longint unsigned p;
      p = (64'(r) * mag + 64'd32768) >> 16;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   // Q28 to mm, round half up, add offset, clamp to 24 bits
   function automatic logic signed [23:0] map_coord(input longint acc_q28,
                                                    input logic signed [23:0] offs);
      longint v;
      v = ((acc_q28 + 64'sd134217728) >>> 28) + longint'(offs);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v[23:0];
   endfunction

   function automatic rsp_payload_type project_point(input req_payload_type item,
                                                     input logic [15:0] angle);
      rsp_payload_type pt;
      longint unsigned s;
      longint unsigned c;
      longint unsigned cm;
      longint unsigned sm;
      logic            cn;
      logic            sn;
      longint          xl;
      longint          yl;
      pt = '0;
      pt.scan_end   = item.scan_last;
      pt.point_kept = item.range_finite && item.range_mm > RANGE_MIN_MM
                      && item.range_mm < RANGE_MAX_MM;
      if (pt.point_kept) begin
         s = quarter_sine({1'b0, angle[13:0]});
         c = quarter_sine(QUARTER_TURN - {1'b0, angle[13:0]});
         case (quad_type'(angle[15:14]))
            QUAD_0: begin
               cm = c; cn = 1'b0; sm = s; sn = 1'b0;
            end
            QUAD_1: begin
               cm = s; cn = 1'b1; sm = c; sn = 1'b0;
            end
            QUAD_2: begin
               cm = c; cn = 1'b1; sm = s; sn = 1'b1;
            end
            default: begin
               cm = s; cn = 1'b0; sm = c; sn = 1'b1;
            end
         endcase
         xl = scale_range(item.range_mm, cm, cn);
         yl = scale_range(item.range_mm, sm, sn);
         pt.point_x = map_coord(longint'(setup.mat_xx) * xl + longint'(setup.mat_xy) * yl,
                                setup.offset_x);
         pt.point_y = map_coord(longint'(setup.mat_yx) * xl + longint'(setup.mat_yy) * yl,
                                setup.offset_y);
      end
      return pt;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         setup       = CFG_RESET;
         beam_angle  = '0;
         error_count = 0;
         point_queue.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_payload.scan_first) beam_angle = setup.angle_start;
            point_queue.insert(point_queue.size(), project_point(req_payload, beam_angle));
            beam_angle = beam_angle + setup.angle_step;
         end
         if (rsp_valid && rsp_ready) begin
            if (point_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected point x=%0d y=%0d kept=%0b end=%0b", $time,
                        rsp_payload.point_x, rsp_payload.point_y, rsp_payload.point_kept,
                        rsp_payload.scan_end);
            end else begin
               want = point_queue.pop_front();
               check_field("point_x", longint'(want.point_x), longint'(rsp_payload.point_x));
               check_field("point_y", longint'(want.point_y), longint'(rsp_payload.point_y));
               check_field("point_kept", longint'(want.point_kept),
                           longint'(rsp_payload.point_kept));
               check_field("scan_end", longint'(want.scan_end),
                           longint'(rsp_payload.scan_end));
            end
         end
         if (csr_wr_en) begin
            case (reg_index_type'(csr_index))
               REG_MAT_XX:      setup.mat_xx      = csr_wdata[15:0];
               REG_MAT_XY:      setup.mat_xy      = csr_wdata[15:0];
               REG_MAT_YX:      setup.mat_yx      = csr_wdata[15:0];
               REG_MAT_YY:      setup.mat_yy      = csr_wdata[15:0];
               REG_OFFSET_X:    setup.offset_x    = csr_wdata[23:0];
               REG_OFFSET_Y:    setup.offset_y    = csr_wdata[23:0];
               REG_ANGLE_START: setup.angle_start = csr_wdata[15:0];
               REG_ANGLE_STEP:  setup.angle_step  = csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      points_pending = point_queue.size();
   end

endmodule

// ===== sim/lidar_scan_to_map_points_unit_tb.sv =====
module lidar_scan_to_map_points_unit_tb;
   import lsmp_pkg::*;

   typedef enum int {
      SETUP_RANDOM,
      SETUP_HIGH,
      SETUP_LOW
   } setup_kind_type;

   localparam int PHASES          = 8;
   localparam int POINTS_PER_SCAN = 175;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam logic [15:0] RANGE_EDGES [6] = '{16'd0, 16'd100, 16'd101, 16'd29999,
                                               16'd30000, 16'd65535};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     error_count;
   int                     points_pending;
   int                     sender_idle_pct   = 35;
   int                     receiver_idle_pct = 72;
   bit                     hold_off_request  = 1'b0;

   lsmp_chan_if #(.payload_type(req_payload_type)) req_chan ();
   lsmp_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   lidar_scan_to_map_points_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lidar_scan_to_map_points_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_payload    (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_payload    (rsp_chan.payload),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .points_pending (points_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // receiver: random stalls plus an occasional long hold-off
   initial begin
      int hold_left;
      hold_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   function automatic req_payload_type make_item(input logic [15:0] range_mm,
                                                 input logic finite, input logic is_first,
                                                 input logic is_last);
      req_payload_type item;
      item.range_mm     = range_mm;
      item.range_finite = finite;
      item.scan_first   = is_first;
      item.scan_last    = is_last;
      return item;
   endfunction

   function automatic logic [15:0] pick_range();
      case ($urandom_range(0, 7))
         0:       return 16'($urandom);
         1:       return RANGE_EDGES[$urandom_range(0, 5)];
         default: return 16'($urandom_range(101, 29999));
      endcase
   endfunction

   function automatic cfg_type pick_setup(input setup_kind_type kind);
      cfg_type c;
      case (kind)
         SETUP_HIGH: begin
            c = '{mat_xx: 16'sh7FFF, mat_xy: 16'sh7FFF, mat_yx: 16'sh7FFF,
                  mat_yy: 16'sh7FFF, offset_x: 24'sh7FFFFF, offset_y: 24'sh7FFFFF,
                  angle_start: 16'hFFFF, angle_step: 16'sh7FFF};
         end
         SETUP_LOW: begin
            c = '{mat_xx: 16'sh8000, mat_xy: 16'sh8000, mat_yx: 16'sh8000,
                  mat_yy: 16'sh8000, offset_x: 24'sh800000, offset_y: 24'sh800000,
                  angle_start: 16'h0000, angle_step: 16'sh8000};
         end
         default: begin
            c.mat_xx      = 16'($urandom);
            c.mat_xy      = 16'($urandom);
            c.mat_yx      = 16'($urandom);
            c.mat_yy      = 16'($urandom);
            c.offset_x    = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(0, 400000) - 200000);
            c.offset_y    = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(0, 400000) - 200000);
            c.angle_start = 16'($urandom);
            c.angle_step  = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 1400) - 700);
         end
      endcase
      return c;
   endfunction

   task automatic write_setup(input cfg_type c);
      reg_index_type          idx;
      logic [31:0]            fill;
      logic [CSR_DATA_W-1:0]  data;
      for (int i = 0; i < 8; i++) begin
         idx  = reg_index_type'(i);
         fill = $urandom;
         case (idx)
            REG_MAT_XX:      data = {fill[7:0], c.mat_xx};
            REG_MAT_XY:      data = {fill[7:0], c.mat_xy};
            REG_MAT_YX:      data = {fill[7:0], c.mat_yx};
            REG_MAT_YY:      data = {fill[7:0], c.mat_yy};
            REG_OFFSET_X:    data = c.offset_x;
            REG_OFFSET_Y:    data = c.offset_y;
            REG_ANGLE_START: data = {fill[7:0], c.angle_start};
            default:         data = {fill[7:0], c.angle_step};
         endcase
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // entered just after an accepting edge or at an idle point
   task automatic send_point(input req_payload_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain_points();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (points_pending != 0) @(negedge clock);
   endtask

   initial begin
      int             sent;
      int             scan_len;
      setup_kind_type kind;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setup: range window edges, non-finite, one-sample scan
      send_point(make_item(16'd0, 1'b1, 1'b1, 1'b0));
      send_point(make_item(16'd100, 1'b1, 1'b0, 1'b0));
      send_point(make_item(16'd101, 1'b1, 1'b0, 1'b0));
      send_point(make_item(16'd29999, 1'b1, 1'b0, 1'b0));
      send_point(make_item(16'd30000, 1'b1, 1'b0, 1'b0));
      send_point(make_item(16'd65535, 1'b1, 1'b0, 1'b0));
      send_point(make_item(16'd5000, 1'b0, 1'b0, 1'b1));
      send_point(make_item(16'd2500, 1'b1, 1'b1, 1'b1));
      drain_points();

      // identity map, sixteenth-turn steps: every quadrant and its boundaries
      write_setup('{mat_xx: 16'sd16384, mat_xy: 16'sd0, mat_yx: 16'sd0,
                    mat_yy: 16'sd16384, offset_x: 24'sd0, offset_y: 24'sd0,
                    angle_start: 16'd0, angle_step: 16'sd4096});
      for (int k = 0; k < 16; k++) begin
         send_point(make_item(16'(12345 + k * 1000), 1'b1, k == 0, k == 15));
      end
      drain_points();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 3) begin
            sender_idle_pct   = 35;
            receiver_idle_pct = 72;
         end else if (phase < 6) begin
            sender_idle_pct   = 72;
            receiver_idle_pct = 35;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         kind = (phase == 1) ? SETUP_HIGH : (phase == 3) ? SETUP_LOW : SETUP_RANDOM;
         write_setup(pick_setup(kind));
         if (phase == 1 || phase == 6) hold_off_request = 1'b1;
         sent = 0;
         while (sent < POINTS_PER_SCAN) begin
            if ($urandom_range(0, 9) == 0) begin
               send_point(make_item(16'($urandom), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
               sent++;
            end else begin
               scan_len = $urandom_range(1, 32);
               for (int k = 0; k < scan_len; k++) begin
                  send_point(make_item(pick_range(), $urandom_range(0, 15) != 0, k == 0,
                                       k == scan_len - 1));
                  sent++;
                  if (phase == 4 && sent == 90) drain_points();
               end
            end
         end
         drain_points();
      end

      repeat (40) @(negedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
